[src/pst_pkg.sv]
`default_nettype none
package pst_pkg;
   localparam int Leaves    = 16;
   localparam int LeafBits  = 4;
   localparam int NodePool  = 4096;
   localparam int NodeBits  = 12;
   localparam int Versions  = 256;
   localparam int VerBits   = 8;
   localparam int ValueBits = 32;
   localparam int Depth     = LeafBits;

   typedef enum logic [1:0] {
      KIND_NEW     = 2'd0,
      KIND_REPLACE = 2'd1,
      KIND_QUERY   = 2'd2,
      KIND_BAD     = 2'd3
   } kind_type;

   typedef struct packed {
      logic [NodeBits-1:0]  left;
      logic [NodeBits-1:0]  right;
      logic [ValueBits-1:0] sum;
   } node_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [VerBits-1:0]   version;
      logic [LeafBits-1:0]  position;
      logic [ValueBits-1:0] value;
      logic [4:0]           range_lo;
      logic [4:0]           range_hi;
   } req_type;

   typedef struct packed {
      logic [VerBits-1:0]   new_version;
      logic [ValueBits-1:0] range_sum;
      logic                 error;
   } rsp_type;
endpackage
`default_nettype wire

[src/pst_if.sv]
`default_nettype none
interface pst_req_if;
   logic             valid;
   logic             ready;
   pst_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface pst_rsp_if;
   logic             valid;
   logic             ready;
   pst_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/persistent_segment_tree_sum_top.sv]
`default_nettype none
// Persistent sum segment tree over 16 signed 32-bit leaves, path copying into a
// 4096-node pool with up to 256 versions. One request gives one response.
// Nodes live in a synchronous memory with one read port and one write port,
// and the root table is a second synchronous memory read on the transfer edge.
// Node 0 is the null node and reads as zero without a memory access. An update
// reads the root entry, then walks five levels down to the old leaf, waiting
// for each stored node but not for a null node, to collect the sibling indices
// and the old sums on the path. It then writes five new nodes leaf first and the
// root table entry. A query visits the tree depth first with a small stack,
// waiting on each node read and popping each entry in a state of its own. A
// refused request goes straight to the response state. One request is in
// progress at a time, and the next request is taken no earlier than the cycle
// in which the previous response transfers.
module persistent_segment_tree_sum_top (
   input wire logic clock,
   input wire logic reset,
   pst_req_if.sink   req,
   pst_rsp_if.source rsp
);
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b0_0000_0001,
      ST_ROOT   = 9'b0_0000_0010,
      ST_DREAD  = 9'b0_0000_0100,
      ST_DWAIT  = 9'b0_0000_1000,
      ST_BUILD  = 9'b0_0001_0000,
      ST_QPOP   = 9'b0_0010_0000,
      ST_QWAIT  = 9'b0_0100_0000,
      ST_DONE   = 9'b0_1000_0000,
      ST_RSP    = 9'b1_0000_0000
   } state_type;

   localparam int NB = pst_pkg::NodeBits;
   localparam int VB = pst_pkg::ValueBits;
   localparam int LB = pst_pkg::LeafBits;

   // Node memory, entry 0 never read.
   pst_pkg::node_type node_mem [pst_pkg::NodePool];
   pst_pkg::node_type rd_ff;
   logic [NB-1:0]     mem_raddr;
   logic              mem_we;
   logic [NB-1:0]     mem_waddr;
   pst_pkg::node_type mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= node_mem[mem_raddr];
   end

   // Root table: entries beyond the latest version are never read. Entry 0 is
   // cleared by reset through the write port.
   logic [NB-1:0] root_mem [pst_pkg::Versions];
   logic [NB-1:0] root_rd_ff;
   logic          root_we;
   logic [pst_pkg::VerBits-1:0] root_waddr;
   logic [NB-1:0] root_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_mem[0] <= '0;
      end else if (root_we) begin
         root_mem[root_waddr] <= root_wdata;
      end
      root_rd_ff <= root_mem[req.data.version];
   end

   state_type state_ff, state_in;
   pst_pkg::req_type op_ff, op_in;
   logic [12:0] free_ff, free_in;
   logic [pst_pkg::VerBits-1:0] latest_ff, latest_in;
   logic [NB-1:0] node_ff, node_in;
   logic [2:0]    lvl_ff, lvl_in;
   logic [NB-1:0] sib_ff [pst_pkg::Depth];
   logic [pst_pkg::Depth-1:0] wl_ff;
   // Old sums of the nodes on the path, root first, old leaf last.
   logic [VB-1:0] nsum_ff [pst_pkg::Depth + 1];
   logic          nsum_we;
   logic [VB-1:0] nsum_wdata;
   logic [VB-1:0] acc_ff, acc_in;
   logic [NB-1:0] cur_ff, cur_in;
   // Query stack entries: node, interval start, level.
   logic [NB-1:0] stn_ff [8];
   logic [LB:0]   stl_ff [8];
   logic [2:0]    stv_ff [8];
   logic [3:0]    sp_ff, sp_in;
   logic [LB:0]   ql_ff, ql_in;
   logic [2:0]    qv_ff, qv_in;
   pst_pkg::rsp_type out_ff, out_in;
   logic out_v_ff, out_v_in;
   logic push_en;
   logic [NB-1:0] pa_n, pb_n;
   logic [LB:0]   pa_l, pb_l;
   logic [2:0]    pc_v;
   logic sib_we;
   logic [LB:0] width_w, mid_w, hi_w;
   logic [12:0] need;

   assign req.ready = state_ff == ST_IDLE && (!out_v_ff || rsp.ready);
   assign rsp.valid = out_v_ff;
   assign rsp.data  = out_ff;

   always_comb begin
      state_in = state_ff; op_in = op_ff; free_in = free_ff; latest_in = latest_ff;
      node_in = node_ff; lvl_in = lvl_ff; acc_in = acc_ff; cur_in = cur_ff;
      sp_in = sp_ff; ql_in = ql_ff; qv_in = qv_ff; out_in = out_ff;
      out_v_in = out_v_ff && !rsp.ready;
      mem_raddr = node_ff; mem_we = 1'b0; mem_waddr = cur_ff; mem_wdata = '0;
      root_we = 1'b0; root_waddr = latest_ff; root_wdata = cur_ff;
      push_en = 1'b0; pa_n = '0; pb_n = '0; pa_l = '0; pb_l = '0;
      pc_v = '0; sib_we = 1'b0; nsum_we = 1'b0; nsum_wdata = '0;
      width_w = (LB+1)'(pst_pkg::Leaves) >> qv_ff;
      mid_w = ql_ff + (width_w >> 1);
      hi_w = ql_ff + width_w;
      need = free_ff + 13'(pst_pkg::Depth + 1);
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               op_in = req.data;
               lvl_in = '0;
               acc_in = '0;
               sp_in = '0;
               if (req.data.kind == pst_pkg::KIND_BAD || req.data.version > latest_ff) begin
                  out_in = '{latest_ff, '0, 1'b1};
                  state_in = ST_RSP;
               end else if (req.data.kind == pst_pkg::KIND_QUERY) begin
                  ql_in = '0; qv_in = '0;
                  state_in = ST_ROOT;
               end else if ((req.data.kind == pst_pkg::KIND_NEW &&
                              latest_ff == pst_pkg::VerBits'(pst_pkg::Versions - 1)) ||
                             need > 13'(pst_pkg::NodePool)) begin
                  out_in = '{latest_ff, '0, 1'b1};
                  state_in = ST_RSP;
               end else begin
                  state_in = ST_ROOT;
               end
            end
         end
         // The root entry of the requested version is now in the read register.
         ST_ROOT: begin
            node_in = root_rd_ff;
            state_in = (op_ff.kind == pst_pkg::KIND_QUERY) ? ST_QWAIT : ST_DREAD;
         end
         // Descent: read the node on the path, remember the sibling and the old sum, then write the new leaf.
         ST_DREAD: begin
            if (lvl_ff == 3'(pst_pkg::Depth + 1)) begin
               cur_in = free_ff[NB-1:0];
               acc_in = op_ff.value;
               mem_we = 1'b1;
               mem_waddr = free_ff[NB-1:0];
               mem_wdata = '{'0, '0, op_ff.value};
               free_in = free_ff + 13'd1;
               lvl_in = 3'(pst_pkg::Depth);
               state_in = ST_BUILD;
            end else if (node_ff == '0) begin
               sib_we = lvl_ff != 3'(pst_pkg::Depth);
               nsum_we = 1'b1;
               lvl_in = lvl_ff + 3'd1;
            end else begin
               state_in = ST_DWAIT;
            end
         end
         ST_DWAIT: begin
            state_in = ST_DREAD;
            node_in = op_ff.position[LB-1-lvl_ff[1:0]] ? rd_ff.right : rd_ff.left;
            sib_we = lvl_ff != 3'(pst_pkg::Depth);
            nsum_we = 1'b1;
            nsum_wdata = rd_ff.sum;
            lvl_in = lvl_ff + 3'd1;
         end
         // Build parents bottom up, then write the root table entry. The sibling's sum
         // is the old parent sum less the old sum of the child on the path.
         ST_BUILD: begin
            if (lvl_ff == '0) begin
               root_we = 1'b1;
               if (op_ff.kind == pst_pkg::KIND_NEW) begin
                  root_waddr = latest_ff + 1'b1;
                  latest_in = latest_ff + 1'b1;
                  out_in = '{latest_ff + 1'b1, '0, 1'b0};
               end else begin
                  out_in = '{latest_ff, '0, 1'b0};
               end
               state_in = ST_RSP;
            end else begin
               mem_we = 1'b1;
               mem_waddr = free_ff[NB-1:0];
               mem_wdata.sum = acc_ff + nsum_ff[lvl_ff - 3'd1] - nsum_ff[lvl_ff];
               if (wl_ff[lvl_ff[1:0] - 2'd1]) begin
                  mem_wdata.left = cur_ff; mem_wdata.right = sib_ff[lvl_ff[1:0] - 2'd1];
               end else begin
                  mem_wdata.left = sib_ff[lvl_ff[1:0] - 2'd1]; mem_wdata.right = cur_ff;
               end
               acc_in = mem_wdata.sum;
               cur_in = free_ff[NB-1:0];
               free_in = free_ff + 13'd1;
               lvl_in = lvl_ff - 3'd1;
            end
         end
         ST_QPOP: begin
            if (sp_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               node_in = stn_ff[sp_ff[2:0] - 3'd1];
               ql_in = stl_ff[sp_ff[2:0] - 3'd1];
               qv_in = stv_ff[sp_ff[2:0] - 3'd1];
               sp_in = sp_ff - 4'd1;
               state_in = ST_QWAIT;
            end
         end
         // Node address is on the read port; classify the interval.
         ST_QWAIT: begin
            state_in = ST_QPOP;
            if (node_ff == '0 || op_ff.range_hi <= ql_ff || hi_w <= op_ff.range_lo) begin
               // no contribution
            end else if (mem_raddr == node_ff && lvl_ff == '0) begin
               lvl_in = 3'd1; state_in = ST_QWAIT;
            end else begin
               lvl_in = '0;
               if (op_ff.range_lo <= ql_ff && hi_w <= op_ff.range_hi) begin
                  acc_in = acc_ff + rd_ff.sum;
               end else begin
                  push_en = 1'b1;
                  pa_n = rd_ff.right; pa_l = mid_w;
                  pb_n = rd_ff.left;  pb_l = ql_ff;
                  pc_v = qv_ff + 3'd1;
               end
            end
         end
         ST_DONE: begin
            out_in = '{latest_ff, acc_ff, 1'b0};
            state_in = ST_RSP;
         end
         ST_RSP: begin
            if (!out_v_ff || rsp.ready) begin
               out_v_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (push_en) begin
         sp_in = sp_ff + 4'd2;
      end
   end

   // Path bookkeeping for the copy, and the query stack.
   always_ff @(posedge clock) begin
      if (sib_we) begin
         wl_ff[lvl_ff[1:0]] <= !op_ff.position[LB-1-lvl_ff[1:0]];
         if (state_ff == ST_DWAIT) begin
            sib_ff[lvl_ff[1:0]] <= op_ff.position[LB-1-lvl_ff[1:0]] ? rd_ff.left : rd_ff.right;
         end else begin
            sib_ff[lvl_ff[1:0]] <= '0;
         end
      end
      if (nsum_we) begin
         nsum_ff[lvl_ff] <= nsum_wdata;
      end
      if (push_en) begin
         stn_ff[sp_ff[2:0]] <= pa_n; stl_ff[sp_ff[2:0]] <= pa_l; stv_ff[sp_ff[2:0]] <= pc_v;
         stn_ff[sp_ff[2:0] + 3'd1] <= pb_n; stl_ff[sp_ff[2:0] + 3'd1] <= pb_l;
         stv_ff[sp_ff[2:0] + 3'd1] <= pc_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; free_ff <= 13'd1; latest_ff <= '0; out_v_ff <= 1'b0;
         sp_ff <= '0; lvl_ff <= '0;
      end else begin
         state_ff <= state_in; free_ff <= free_in; latest_ff <= latest_in;
         out_v_ff <= out_v_in; sp_ff <= sp_in; lvl_ff <= lvl_in;
      end
      op_ff <= op_in; node_ff <= node_in; acc_ff <= acc_in; cur_ff <= cur_in;
      ql_ff <= ql_in; qv_ff <= qv_in; out_ff <= out_in;
   end
endmodule
`default_nettype wire

[src/pst_checker.sv]
`default_nettype none
module pst_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [31:0] rsp_sum,
   input wire logic rsp_error
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_sum == '0)
      else $error("refused request carries a sum");
   a_no_back: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken at once");
endmodule

bind persistent_segment_tree_sum_top pst_checker u_pst_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_sum(rsp.data.range_sum), .rsp_error(rsp.data.error)
);
`default_nettype wire

[tb/tb_persistent_segment_tree_sum_top.sv]
`default_nettype none
module tb_persistent_segment_tree_sum_top;
   import pst_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   pst_req_if req ();
   pst_rsp_if rsp ();

   persistent_segment_tree_sum_top DUT (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   // Our own copy of the versioned tree. Node 0 is the shared null node, and
   // every other node is written by an update before anything reads it.
   logic [NodeBits-1:0]  tree_left  [NodePool];
   logic [NodeBits-1:0]  tree_right [NodePool];
   logic [ValueBits-1:0] tree_sum   [NodePool];
   logic [NodeBits-1:0]  version_root [Versions];
   int                   free_node;
   int                   newest_version;

   // Responses still owed by the block, oldest at the front.
   rsp_type answers_due [$];
   bit      failed = 1'b0;
   bit      quiet  = 1'b0;   // set for the final stretch, where nobody stalls
   int      cycles = 0;

   // Wrapping sum over the leaves [a, b) below node, which spans [l, r).
   function automatic logic [ValueBits-1:0] span_total(int node, int a, int b, int l, int r);
      int m;
      if (node == 0 || b <= l || r <= a) return '0;
      if (a <= l && r <= b) return tree_sum[node];
      m = l + (r - l) / 2;
      return span_total(tree_left[node], a, b, l, m) + span_total(tree_right[node], a, b, m, r);
   endfunction

   // Applies one request to the copy of the tree and returns what the block
   // should answer. A refused request leaves the state untouched.
   function automatic rsp_type tree_predict(req_type r);
      rsp_type              ans;
      logic [NodeBits-1:0]  sibling [Depth];
      bit                   went_left [Depth];
      int                   node, l, hi, m, cur, p;
      logic [NodeBits-1:0]  s;
      ans.new_version = newest_version[VerBits-1:0];
      ans.range_sum   = '0;
      ans.error       = 1'b0;
      if (r.kind == KIND_BAD || r.version > newest_version) begin
         ans.error = 1'b1;
      end else if (r.kind == KIND_QUERY) begin
         ans.range_sum = span_total(version_root[r.version], r.range_lo, r.range_hi, 0, Leaves);
      end else if ((r.kind == KIND_NEW && newest_version + 1 >= Versions) ||
                   free_node + Depth + 1 > NodePool) begin
         ans.error = 1'b1;
      end else begin
         // Walk down, remembering each sibling, then copy the path leaf first.
         node = version_root[r.version];
         l    = 0;
         hi   = Leaves;
         for (int d = 0; d < Depth; d++) begin
            m = l + (hi - l) / 2;
            went_left[d] = r.position < m;
            sibling[d]   = went_left[d] ? tree_right[node] : tree_left[node];
            node         = went_left[d] ? tree_left[node] : tree_right[node];
            if (went_left[d]) hi = m;
            else l = m;
         end
         cur = free_node++;
         tree_left[cur]  = '0;
         tree_right[cur] = '0;
         tree_sum[cur]   = r.value;
         for (int d = Depth - 1; d >= 0; d--) begin
            p = free_node++;
            s = sibling[d];
            tree_left[p]  = went_left[d] ? cur[NodeBits-1:0] : s;
            tree_right[p] = went_left[d] ? s : cur[NodeBits-1:0];
            tree_sum[p]   = tree_sum[cur] + tree_sum[s];
            cur = p;
         end
         if (r.kind == KIND_NEW) newest_version++;
         version_root[newest_version] = cur[NodeBits-1:0];
         ans.new_version = newest_version[VerBits-1:0];
      end
      return ans;
   endfunction

   function automatic req_type make_req(kind_type k, int ver, int pos, logic [31:0] val,
                                        int lo, int hi);
      req_type r;
      r.kind     = k;
      r.version  = ver[VerBits-1:0];
      r.position = pos[LeafBits-1:0];
      r.value    = val;
      r.range_lo = lo[4:0];
      r.range_hi = hi[4:0];
      return r;
   endfunction

   // Offers one request, with an optional gap in front of it, and waits for the
   // transfer. The prediction is made as the request is taken.
   task automatic offer(req_type r, bit typed, rsp_type typed_ans);
      rsp_type ans;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data  <= r;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      ans = tree_predict(r);
      answers_due.push_back(typed ? typed_ans : ans);
   endtask

   // The receiving side stalls in short bursts, except in the final stretch.
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp.ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp.ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp.ready <= 1'b0;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // Every response transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (answers_due.size() == 0) begin
            $display("%0t: response with nothing expected: %p", $time, rsp.data);
            failed = 1'b1;
         end else begin
            want = answers_due.pop_front();
            if (rsp.data.new_version !== want.new_version) begin
               $display("%0t: new_version expected %0d, got %0d", $time,
                        want.new_version, rsp.data.new_version);
               failed = 1'b1;
            end
            if (rsp.data.range_sum !== want.range_sum) begin
               $display("%0t: range_sum expected %h, got %h", $time,
                        want.range_sum, rsp.data.range_sum);
               failed = 1'b1;
            end
            if (rsp.data.error !== want.error) begin
               $display("%0t: error expected %b, got %b", $time, want.error, rsp.data.error);
               failed = 1'b1;
            end
         end
      end
   end

   // Watchdog: far beyond the slowest legal run of the whole stimulus.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("persistent_segment_tree_sum_top: mismatch");
         $finish;
      end
   end

   typedef struct {
      req_type r;
      bit      typed;
      rsp_type ans;
   } row_type;

   initial begin
      row_type rows [$];
      req_type r;
      int      pick, ver, lo, hi;
      logic [31:0] val;

      req.valid <= 1'b0;
      req.data  <= '0;
      for (int i = 0; i < NodePool; i++) begin
         tree_left[i]  = '0;
         tree_right[i] = '0;
         tree_sum[i]   = '0;
      end
      for (int i = 0; i < Versions; i++) version_root[i] = '0;
      free_node      = 1;
      newest_version = 0;

      // Directed rows. Answers are written in only where they are obvious:
      // the empty tree, the first two new versions, refusals and empty ranges.
      rows.push_back('{make_req(KIND_QUERY, 0, 0, 0, 0, 16), 1, '{8'd0, 32'd0, 1'b0}});
      rows.push_back('{make_req(KIND_QUERY, 1, 0, 0, 0, 16), 1, '{8'd0, 32'd0, 1'b1}});
      rows.push_back('{make_req(KIND_BAD, 0, 3, 32'h5, 0, 16), 1, '{8'd0, 32'd0, 1'b1}});
      rows.push_back('{make_req(KIND_NEW, 0, 0, 32'h7fffffff, 0, 0), 1, '{8'd1, 32'd0, 1'b0}});
      rows.push_back('{make_req(KIND_NEW, 1, 15, 32'h80000000, 0, 0), 1, '{8'd2, 32'd0, 1'b0}});
      rows.push_back('{make_req(KIND_QUERY, 2, 0, 0, 0, 16), 0, '{default: '0}});
      rows.push_back('{make_req(KIND_NEW, 2, 7, 32'h7fffffff, 0, 0), 0, '{default: '0}});
      rows.push_back('{make_req(KIND_QUERY, 3, 0, 0, 0, 31), 0, '{default: '0}});
      rows.push_back('{make_req(KIND_REPLACE, 1, 7, 32'hffffffff, 0, 0), 0, '{default: '0}});
      rows.push_back('{make_req(KIND_QUERY, 3, 0, 0, 0, 16), 0, '{default: '0}});
      rows.push_back('{make_req(KIND_QUERY, 3, 0, 0, 16, 16), 1, '{8'd3, 32'd0, 1'b0}});
      rows.push_back('{make_req(KIND_QUERY, 3, 0, 0, 10, 3), 1, '{8'd3, 32'd0, 1'b0}});
      rows.push_back('{make_req(KIND_QUERY, 3, 0, 0, 31, 31), 1, '{8'd3, 32'd0, 1'b0}});
      rows.push_back('{make_req(KIND_QUERY, 3, 0, 0, 15, 31), 0, '{default: '0}});
      rows.push_back('{make_req(KIND_QUERY, 255, 0, 0, 0, 16), 1, '{8'd3, 32'd0, 1'b1}});
      rows.push_back('{make_req(KIND_REPLACE, 4, 1, 32'h1, 0, 0), 1, '{8'd3, 32'd0, 1'b1}});
      rows.push_back('{make_req(KIND_QUERY, 1, 0, 0, 0, 8), 0, '{default: '0}});
      rows.push_back('{make_req(KIND_QUERY, 2, 0, 0, 8, 16), 0, '{default: '0}});

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) offer(rows[i].r, rows[i].typed, rows[i].ans);

      // Random part. Most requests name a version that exists; new versions
      // are frequent enough that the version table fills up well before the end,
      // so refusals for a full table are reached.
      for (int n = 0; n < 2000; n++) begin
         if (n >= 1800) quiet = 1'b1;
         pick = $urandom_range(0, 99);
         ver  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, newest_version);
         case ($urandom_range(0, 3))
            0: val = 32'h7fffffff;
            1: val = 32'h80000000;
            default: val = $urandom;
         endcase
         if ($urandom_range(0, 4) == 0) begin
            lo = $urandom_range(0, 31);
            hi = $urandom_range(0, 31);
         end else begin
            lo = $urandom_range(0, 16);
            hi = $urandom_range(lo, 16);
         end
         if (pick < 35)      r = make_req(KIND_NEW, ver, $urandom_range(0, 15), val, lo, hi);
         else if (pick < 55) r = make_req(KIND_REPLACE, ver, $urandom_range(0, 15), val, lo, hi);
         else if (pick < 96) r = make_req(KIND_QUERY, ver, $urandom_range(0, 15), val, lo, hi);
         else                r = make_req(KIND_BAD, ver, $urandom_range(0, 15), val, lo, hi);
         offer(r, 1'b0, '{default: '0});
      end
      req.valid <= 1'b0;

      // Drain, then allow a little longer for any stray response to show up.
      while (answers_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (!failed) begin
         $display("persistent_segment_tree_sum_top: match");
      end else begin
         $display("persistent_segment_tree_sum_top: mismatch");
      end
      $finish;
   end
endmodule
`default_nettype wire
